[sv/qps_pkg.sv]
// Package of shared types and constants for the quota priority scheduler.
package qps_pkg;

  localparam int CLASSES_DEF     = 8;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TAG_BITS_DEF    = 16;
  localparam int CLS_W           = 3;
  localparam int RUN_W           = 16;

  typedef enum logic [1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_START  = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_UNDER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CFG_MIN     = 3'd0,
    CFG_MAX_LO  = 3'd1,
    CFG_MAX_HI  = 3'd2,
    CFG_ENABLE  = 3'd3,
    CFG_DEFAULT = 3'd4,
    CFG_SHUT    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2,
    S_RESP = 2'd3
  } state_t;

  // Controller commands to the datapath.
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic execute;   // decide and update per-class state
    logic respond;   // drive the result strobe
  } cmd_t;

  // Datapath status to the controller.
  typedef struct packed {
    logic is_deq_grant;  // the executed item popped a tag
  } stat_t;

endpackage

[sv/qps_datapath.sv]
// Datapath: configuration registers, per-class queues and counters, tag memory.
module qps_datapath import qps_pkg::*; #(
  parameter int CLASSES     = CLASSES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_prio,
  input  logic [15:0]         in_tag,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_wdata,
  output logic                out_granted,
  output logic [CLS_W-1:0]    out_class,
  output logic [15:0]         out_tag,
  output logic [1:0]          out_status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CI_W  = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int MEM_D = CLASSES * QUEUE_DEPTH;
  localparam int ADR_W = $clog2(MEM_D);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic [63:0]      min_limits_r;
  logic [63:0]      max_lo_r;
  logic [63:0]      max_hi_r;
  logic [7:0]       enable_r;
  logic [2:0]       default_r;
  logic             shut_r;

  logic [1:0]          op_r;
  logic [7:0]          prio_r;
  logic [TAG_BITS-1:0] tag_r;

  logic [PTR_W-1:0] head_r [CLASSES];
  logic [PTR_W-1:0] tail_r [CLASSES];
  logic [CNT_W-1:0] pend_r [CLASSES];
  logic [RUN_W-1:0] run_r  [CLASSES];

  logic [TAG_BITS-1:0] mem [MEM_D];
  logic [TAG_BITS-1:0] rd_data_r;

  logic             granted_r;
  logic [CLS_W-1:0] cls_r;
  logic [1:0]       status_r;

  // Class selection.
  logic [CI_W-1:0] fb_cls;
  logic [CI_W-1:0] map_cls;
  logic [CI_W-1:0] pick_cls;
  logic            found;
  logic [CLASSES-1:0] live, elig_min, elig_max;

  function automatic logic in_prio_ok();
    return prio_r < 8'(CLASSES);
  endfunction

  always_comb begin
    if ({1'b0, default_r} >= 4'(CLASSES)) fb_cls = CI_W'(CLASSES - 1);
    else                                  fb_cls = CI_W'(default_r);
    if (in_prio_ok() && enable_r[prio_r[2:0]]) map_cls = CI_W'(prio_r);
    else                                        map_cls = fb_cls;
  end

  always_comb begin
    for (int c = 0; c < CLASSES; c++) begin
      live[c]     = enable_r[c] || (CI_W'(c) == fb_cls);
      elig_min[c] = live[c] && (pend_r[c] != '0) &&
                    (run_r[c] < {8'd0, min_limits_r[8*c +: 8]});
      elig_max[c] = live[c] && (pend_r[c] != '0) &&
                    (run_r[c] < ((c >= 4) ? max_hi_r[16*(c & 3) +: 16]
                                          : max_lo_r[16*(c & 3) +: 16]));
    end
    if (shut_r) elig_min = '0;
    found    = 1'b0;
    pick_cls = '0;
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (elig_max[c]) begin
        found    = 1'b1;
        pick_cls = CI_W'(c);
      end
    end
    for (int c = CLASSES - 1; c >= 0; c--) begin
      if (elig_min[c]) begin
        found    = 1'b1;
        pick_cls = CI_W'(c);
      end
    end
  end

  logic is_deq;
  assign is_deq = (op_r == OP_DEQ);
  assign stat.is_deq_grant = granted_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_limits_r <= 64'd72340172838076673;
      max_lo_r     <= 64'd844437815230467;
      max_hi_r     <= 64'd844437815230467;
      enable_r     <= 8'hFF;
      default_r    <= 3'd7;
      shut_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MIN:     min_limits_r <= cfg_wdata;
        CFG_MAX_LO:  max_lo_r     <= cfg_wdata;
        CFG_MAX_HI:  max_hi_r     <= cfg_wdata;
        CFG_ENABLE:  enable_r     <= cfg_wdata[7:0];
        CFG_DEFAULT: default_r    <= cfg_wdata[2:0];
        CFG_SHUT:    shut_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_op;
      prio_r <= in_prio;
      tag_r  <= TAG_BITS'(in_tag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CLASSES; c++) begin
        head_r[c] <= '0;
        tail_r[c] <= '0;
        pend_r[c] <= '0;
        run_r[c]  <= '0;
      end
      granted_r <= 1'b0;
      cls_r     <= '0;
      status_r  <= ST_OK;
    end else if (cmd.execute) begin
      granted_r <= 1'b0;
      status_r  <= ST_OK;
      if (is_deq) begin
        if (found) begin
          granted_r        <= 1'b1;
          cls_r            <= CLS_W'(pick_cls);
          head_r[pick_cls] <= (head_r[pick_cls] == PTR_LAST) ? '0 : head_r[pick_cls] + 1'b1;
          pend_r[pick_cls] <= pend_r[pick_cls] - 1'b1;
        end else begin
          cls_r    <= '0;
          status_r <= ST_EMPTY;
        end
      end else begin
        cls_r <= CLS_W'(map_cls);
        case (op_t'(op_r))
          OP_ENQ: begin
            if (pend_r[map_cls] >= CNT_FULL) status_r <= ST_FULL;
            else begin
              tail_r[map_cls] <= (tail_r[map_cls] == PTR_LAST) ? '0 : tail_r[map_cls] + 1'b1;
              pend_r[map_cls] <= pend_r[map_cls] + 1'b1;
            end
          end
          OP_START: begin
            if (run_r[map_cls] != '1) run_r[map_cls] <= run_r[map_cls] + 1'b1;
          end
          default: begin
            if (run_r[map_cls] == '0) status_r <= ST_UNDER;
            else run_r[map_cls] <= run_r[map_cls] - 1'b1;
          end
        endcase
      end
    end
  end

  // Tag memory: one write port for enqueue, one registered read for dequeue.
  logic [ADR_W-1:0] wr_addr, rd_addr;
  logic             mem_we;
  assign wr_addr = ADR_W'(map_cls) * ADR_W'(QUEUE_DEPTH) + ADR_W'(tail_r[map_cls]);
  assign rd_addr = ADR_W'(pick_cls) * ADR_W'(QUEUE_DEPTH) + ADR_W'(head_r[pick_cls]);
  assign mem_we  = cmd.execute && (op_r == OP_ENQ) && (pend_r[map_cls] < CNT_FULL);

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= tag_r;
    if (cmd.execute) rd_data_r <= mem[rd_addr];
  end

  assign out_granted = cmd.respond & granted_r;
  assign out_class   = cls_r;
  assign out_tag     = (cmd.respond && granted_r) ? 16'(rd_data_r) : 16'd0;
  assign out_status  = status_r;

endmodule

[sv/qps_ctrl.sv]
// Controller state machine sequencing capture, execute and response.
module qps_ctrl import qps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output logic  busy,
  output logic  done,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_READ;
      S_READ:  state_nxt = S_RESP;
      S_RESP:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd     = '0;
    busy    = 1'b1;
    done    = 1'b0;
    case (state_r)
      S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      S_EXEC:  cmd.execute = 1'b1;
      S_READ:  ;
      S_RESP: begin
        cmd.respond = 1'b1;
        done        = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_exec_then_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> state_r == S_READ) else $error("exec not followed by read");
  a_start_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> cmd.execute) else $error("accepted item not executed");
  a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> ##1 done) else $error("result not strobed");
  a_grant_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && stat.is_deq_grant) |=> stat.is_deq_grant)
    else $error("grant flag changed before response");
`endif

endmodule

[sv/quota_priority_scheduler_unit.sv]
// Top level of the quota priority scheduler: controller plus datapath.
//
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+-----------------------
//  input    | in_op, in_prio, in_tag                        | start high, busy low
//  result   | out_granted, out_class, out_tag, out_status   | out_valid one cycle
//  config   | cfg_index, cfg_wdata                          | cfg_valid and cfg_ready
//
// After acceptance each item passes through an execute state, which makes the
// per-class decision, updates the counters and reads the tag memory into its
// output register, then a wait state, then a response state with out_valid high.
// The controller handles one item at a time: the next item is accepted in the
// cycle after the result strobe.
// Reset is synchronous and active low; it clears all pointers and counts and
// returns the configuration registers to their reset values. The tag memory
// is not cleared. The receiver cannot stall results.
module quota_priority_scheduler_unit import qps_pkg::*; #(
  parameter int CLASSES     = CLASSES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = TAG_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_prio,
  input  logic [15:0] in_tag,
  output logic        out_valid,
  output logic        out_granted,
  output logic [2:0]  out_class,
  output logic [15:0] out_tag,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  cmd_t  cmd;
  stat_t stat;

  // Configuration is always accepted; the user writes only while idle.
  assign cfg_ready = 1'b1;

  qps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .done  (out_valid),
    .cmd   (cmd)
  );

  qps_datapath #(
    .CLASSES     (CLASSES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_op),
    .in_prio     (in_prio),
    .in_tag      (in_tag),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .out_granted (out_granted),
    .out_class   (out_class),
    .out_tag     (out_tag),
    .out_status  (out_status)
  );

endmodule

[bench/tb_quota_priority_scheduler_unit.sv]
// Testbench for the quota priority scheduler: random and directed items checked against a predictor.
`timescale 1ns / 1ps

// Scoreboard: holds a copy of the scheduler state, predicts each result and checks it.
class sched_scoreboard;
  typedef struct packed {
    logic        granted;
    logic [2:0]  cls;
    logic [15:0] tag;
    logic [1:0]  status;
  } sched_result_t;

  logic [63:0] min_limits, max_lo, max_hi;
  logic [7:0]  enable;
  logic [2:0]  dflt;
  logic        shut;
  logic [15:0] tags [8][64];
  int          head [8];
  int          tail [8];
  int          pending [8];
  int          running [8];
  sched_result_t expected_q [$];
  int          mismatches;

  function new();
    min_limits = 64'd72340172838076673;
    max_lo     = 64'd844437815230467;
    max_hi     = 64'd844437815230467;
    enable     = 8'hFF;
    dflt       = 3'd7;
    shut       = 1'b0;
    mismatches = 0;
    for (int c = 0; c < 8; c++) begin
      head[c] = 0; tail[c] = 0; pending[c] = 0; running[c] = 0;
    end
  endfunction

  function void write_reg(qps_pkg::cfg_idx_t idx, logic [63:0] v);
    case (idx)
      qps_pkg::CFG_MIN:     min_limits = v;
      qps_pkg::CFG_MAX_LO:  max_lo = v;
      qps_pkg::CFG_MAX_HI:  max_hi = v;
      qps_pkg::CFG_ENABLE:  enable = v[7:0];
      qps_pkg::CFG_DEFAULT: dflt = v[2:0];
      qps_pkg::CFG_SHUT:    shut = v[0];
      default: ;
    endcase
  endfunction

  function bit live(int c);
    return enable[c] || c == dflt;
  endfunction

  function int min_of(int c);
    return int'(min_limits[8*c +: 8]);
  endfunction

  function int max_of(int c);
    return c < 4 ? int'(max_lo[16*c +: 16]) : int'(max_hi[16*(c-4) +: 16]);
  endfunction

  function int pending_of(int c);
    return pending[c];
  endfunction

  // Works out the result of one accepted item and updates the state copy.
  function void note_item(qps_pkg::op_t op, logic [7:0] prio, logic [15:0] tag);
    sched_result_t r;
    bit found;
    int c, cls;
    r = '0;
    found = 0;
    cls = 0;
    if (op == qps_pkg::OP_DEQ) begin
      if (!shut)
        for (c = 0; c < 8 && !found; c++)
          if (live(c) && pending[c] > 0 && running[c] < min_of(c)) begin
            found = 1; cls = c;
          end
      for (c = 0; c < 8 && !found; c++)
        if (live(c) && pending[c] > 0 && running[c] < max_of(c)) begin
          found = 1; cls = c;
        end
      if (found) begin
        r.granted = 1'b1;
        r.cls = cls[2:0];
        r.tag = tags[cls][head[cls]];
        head[cls] = (head[cls] + 1) % 64;
        pending[cls]--;
      end else begin
        r.status = qps_pkg::ST_EMPTY;
      end
    end else begin
      cls = (prio < 8 && enable[prio[2:0]]) ? int'(prio) : int'(dflt);
      r.cls = cls[2:0];
      if (op == qps_pkg::OP_ENQ) begin
        if (pending[cls] >= 64) r.status = qps_pkg::ST_FULL;
        else begin
          tags[cls][tail[cls]] = tag;
          tail[cls] = (tail[cls] + 1) % 64;
          pending[cls]++;
        end
      end else if (op == qps_pkg::OP_START) begin
        if (running[cls] < 65535) running[cls]++;
      end else begin
        if (running[cls] == 0) r.status = qps_pkg::ST_UNDER;
        else running[cls]--;
      end
    end
    expected_q.push_back(r);
  endfunction

  function void check_result(logic g, logic [2:0] cls, logic [15:0] tag, logic [1:0] st);
    sched_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result g=%0d c=%0d t=%h s=%0d", g, cls, tag, st);
      return;
    end
    e = expected_q.pop_front();
    if (e.granted !== g || e.cls !== cls || e.tag !== tag || e.status !== st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected g=%0d c=%0d t=%h s=%0d, got g=%0d c=%0d t=%h s=%0d",
                 e.granted, e.cls, e.tag, e.status, g, cls, tag, st);
    end
  endfunction
endclass

module tb_quota_priority_scheduler_unit;
  import qps_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [7:0]  in_prio = '0;
  logic [15:0] in_tag = '0;
  logic        out_valid, out_granted;
  logic [2:0]  out_class;
  logic [15:0] out_tag;
  logic [1:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  sched_scoreboard sb;
  int  idle_cycles = 0;   // consecutive cycles with no handshake of any kind
  bit  calm;              // when set, the sender never idles

  quota_priority_scheduler_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results are sampled at the rising edge; the receiver never stalls.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_granted, out_class, out_tag, out_status);
  end

  // The watchdog counts cycles in which neither an item, a result nor a register write moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Presents one item and holds it until accepted. The sender idles at random first.
  // The block stays busy through its execute, wait and response states after an accept, so
  // waiting one more falling edge before returning costs no throughput.
  task automatic send_item(op_t op, logic [7:0] prio, logic [15:0] tag);
    while (!calm && $urandom_range(99) < 35) @(negedge clk);
    start   <= 1'b1;
    in_op   <= op;
    in_prio <= prio;
    in_tag  <= tag;
    do @(posedge clk); while (busy);
    sb.note_item(op, prio, tag);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every expected result has come, and then for an extra margin.
  task automatic drain();
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random prio: mostly valid classes, sometimes out of range.
  function automatic logic [7:0] rand_prio();
    return ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
  endfunction

  // A random phase of items. The mix leans toward enqueue and dequeue, with start and
  // finish kept in balance so that quotas are both hit and released.
  task automatic random_phase(int n);
    int k;
    logic [7:0] p;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      p = rand_prio();
      if (k < 40) send_item(OP_ENQ, p, 16'($urandom));
      else if (k < 75) send_item(OP_DEQ, p, 16'($urandom));
      else if (k < 88) send_item(OP_START, p, 16'($urandom));
      else send_item(OP_FINISH, p, 16'($urandom));
    end
  endtask

  initial begin
    sb = new();
    calm = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: field extremes, each operation and the special cases.
    send_item(OP_DEQ, 8'h00, 16'h0000);          // nothing eligible after reset
    send_item(OP_FINISH, 8'h00, 16'h0000);       // finish at zero is flagged
    send_item(OP_ENQ, 8'h00, 16'hFFFF);
    send_item(OP_ENQ, 8'hFF, 16'h0000);          // out-of-range prio goes to default
    send_item(OP_ENQ, 8'h08, 16'hA5A5);
    send_item(OP_START, 8'h00, 16'h5A5A);
    send_item(OP_DEQ, 8'hFF, 16'hFFFF);          // class 0 is at its minimum
    send_item(OP_DEQ, 8'h00, 16'h0000);
    send_item(OP_FINISH, 8'h00, 16'h0000);
    send_item(OP_DEQ, 8'h00, 16'h0000);
    send_item(OP_DEQ, 8'h00, 16'h0000);
    // Fill class 3 past its depth so that the full-queue drop is seen.
    calm = 1;
    for (int i = 0; i < 66; i++) send_item(OP_ENQ, 8'h03, 16'(i));
    drain();

    // Disable classes 2 and 3 and move the default to class 2: class 3 tags stay hidden.
    write_reg(CFG_ENABLE, 8'hF3);
    write_reg(CFG_DEFAULT, 3'd2);
    send_item(OP_ENQ, 8'h03, 16'h1234);
    send_item(OP_DEQ, 8'h00, 16'h0000);
    send_item(OP_START, 8'h03, 16'h0000);
    send_item(OP_FINISH, 8'h03, 16'h0000);
    drain();
    // A disabled default class is still live.
    write_reg(CFG_ENABLE, 8'h00);
    write_reg(CFG_DEFAULT, 3'd5);
    send_item(OP_ENQ, 8'h01, 16'hBEEF);
    send_item(OP_DEQ, 8'h00, 16'h0000);
    drain();
    write_reg(CFG_ENABLE, 8'hFF);
    write_reg(CFG_DEFAULT, 3'd7);
    write_reg(CFG_SHUT, 1'b1);
    send_item(OP_DEQ, 8'h00, 16'h0000);
    // Zero quotas: no class is eligible, so every dequeue reports nothing eligible.
    drain();
    write_reg(CFG_MAX_LO, 64'h0);
    write_reg(CFG_MAX_HI, 64'h0);
    write_reg(CFG_MIN, 64'h0);
    write_reg(CFG_SHUT, 1'b0);
    random_phase(60);
    drain();

    // Long stretch with no sender idling, maximum quotas.
    calm = 1;
    write_reg(CFG_MIN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_MAX_LO, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_MAX_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    random_phase(100);
    drain();
    calm = 0;

    // Tight quotas and random settings.
    write_reg(CFG_MIN, {$urandom, $urandom} & 64'h0303_0303_0303_0303);
    write_reg(CFG_MAX_LO, {$urandom, $urandom} & 64'h0007_0007_0007_0007);
    write_reg(CFG_MAX_HI, {$urandom, $urandom} & 64'h0007_0007_0007_0007);
    write_reg(CFG_ENABLE, 8'($urandom));
    write_reg(CFG_DEFAULT, 3'($urandom));
    random_phase(90);
    drain();

    write_reg(CFG_SHUT, 1'b1);
    write_reg(CFG_ENABLE, 8'hFF);
    write_reg(CFG_MIN, 64'h0101_0101_0101_0101);
    random_phase(90);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
